[rtl/vidya_adaptive_average_defines.svh]
// Assertion macros used by the block's datapath module.
`ifndef VIDYA_ADAPTIVE_AVERAGE_DEFINES_SVH
`define VIDYA_ADAPTIVE_AVERAGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VAA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vaa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VAA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vaa assertion failed");

`endif

[rtl/vaa_pkg.sv]
package vaa_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int FRAC_BITS  = 16;

    localparam int PRICE_W = 32;
    localparam int RATIO_W = FRAC_BITS + 1;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int RING_AW = $clog2(MAX_WINDOW);
    localparam int PER_W   = RING_AW + 1;
    localparam int IDX_W   = 7;
    localparam int MOM_W   = PRICE_W + 1;
    localparam int SUM_W   = 39;
    localparam int TOT_W   = SUM_W + 1;
    localparam int DIV_BITS = PRICE_W;
    localparam int CNT_W   = $clog2(DIV_BITS + 1);
    localparam int PROD_W  = RATIO_W + PRICE_W;
    localparam int XS_W    = PROD_W - FRAC_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_CMO_PERIOD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VIDYA_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] CMO_PERIOD_RESET   = 6'd10;
    localparam logic [CFG_W-1:0] VIDYA_PERIOD_RESET = 6'd14;
    localparam logic [CFG_W-1:0] MIN_PERIOD         = 6'd2;
    localparam logic [IDX_W-1:0] IDX_MAX            = 7'd127;
    localparam logic [RATIO_W-1:0] RATIO_ONE        = RATIO_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               series_start;
    } sample_t;

    typedef struct packed {
        logic [PRICE_W-1:0] average;
        logic [RATIO_W-1:0] ratio;
    } result_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic update;
        logic ratio_ld;
        logic ratio_take;
        logic mul;
        logic step_ld;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/vaa_div.sv]
module vaa_div
    import vaa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CNT_W-1:0]    count_init,
    input  logic [TOT_W-1:0]    rem_init,
    input  logic [DIV_BITS-1:0] bits_init,
    input  logic [TOT_W-1:0]    divisor,
    output logic                busy,
    output logic [DIV_BITS-1:0] quotient
);

    logic                busy_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TOT_W-1:0]    rem_reg;
    logic [TOT_W-1:0]    div_reg;
    logic [DIV_BITS-1:0] bits_reg;
    logic [DIV_BITS-1:0] quot_reg;
    logic [TOT_W:0]      trial;
    logic                fits;

    always_comb
    begin
        trial = {rem_reg, bits_reg[DIV_BITS-1]};
        fits  = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= count_init;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            bits_reg <= bits_init;
            div_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? TOT_W'(trial - {1'b0, div_reg}) : trial[TOT_W-1:0];
            bits_reg <= {bits_reg[DIV_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_BITS-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

[rtl/vaa_datapath.sv]
`include "vidya_adaptive_average_defines.svh"

module vaa_datapath
    import vaa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  sample_t              sample,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           sts,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result
);

    logic [CFG_W-1:0]   cmo_reg;
    logic [CFG_W-1:0]   vid_reg;
    logic [IDX_W-1:0]   n_reg;
    logic [PRICE_W-1:0] last_reg;
    logic [RING_AW-1:0] ptr_reg;
    logic [SUM_W-1:0]   up_reg;
    logic [SUM_W-1:0]   down_reg;
    logic [PRICE_W-1:0] avg_reg;
    logic               result_valid_reg;

    logic [PRICE_W-1:0] price_reg;
    logic [MOM_W-1:0]   rd_reg;
    logic [RATIO_W-1:0] k_reg;
    logic [PRICE_W-1:0] mag_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               tot_zero_reg;
    result_t            result_reg;

    logic [MOM_W-1:0]   ring [MAX_WINDOW];

    logic [PER_W-1:0]   p_eff;
    logic [CFG_W-1:0]   v_eff;
    logic [RING_AW-1:0] ptr_wrap;
    logic [RING_AW-1:0] ptr_adv;
    logic [IDX_W:0]     n_plus;
    logic               mom_on;
    logic               evict;
    logic [MOM_W-1:0]   mom;
    logic [MOM_W-1:0]   new_up;
    logic [MOM_W-1:0]   new_down;
    logic [MOM_W-1:0]   old_up;
    logic [MOM_W-1:0]   old_down;
    logic [SUM_W-1:0]   up_next;
    logic [SUM_W-1:0]   down_next;
    logic [TOT_W-1:0]   total;
    logic [SUM_W-1:0]   diff;
    logic [XS_W-1:0]    xs;
    logic [PRICE_W-1:0] avg_next;

    logic                div_start;
    logic [CNT_W-1:0]    div_count;
    logic [TOT_W-1:0]    div_rem;
    logic [DIV_BITS-1:0] div_bits;
    logic [TOT_W-1:0]    div_divisor;
    logic                div_busy;
    logic [DIV_BITS-1:0] div_q;

    always_comb
    begin
        if (cmo_reg < MIN_PERIOD)
        begin
            p_eff = PER_W'(MIN_PERIOD);
        end
        else if ({1'b0, cmo_reg} > PER_W'(MAX_WINDOW))
        begin
            p_eff = PER_W'(MAX_WINDOW);
        end
        else
        begin
            p_eff = PER_W'(cmo_reg);
        end
        v_eff = (vid_reg < MIN_PERIOD) ? MIN_PERIOD : vid_reg;

        ptr_wrap = ({1'b0, ptr_reg} >= p_eff) ? '0 : ptr_reg;
        ptr_adv  = (({1'b0, ptr_reg} + PER_W'(1)) >= p_eff) ? '0 : ptr_reg + RING_AW'(1);

        n_plus = {1'b0, n_reg} + (IDX_W+1)'(1);
        mom_on = (n_plus >= (IDX_W+1)'(p_eff));
        evict  = (n_plus >= (IDX_W+1)'({p_eff, 1'b0}));

        mom      = {1'b0, price_reg} - {1'b0, last_reg};
        new_up   = mom[MOM_W-1] ? '0 : mom;
        new_down = mom[MOM_W-1] ? MOM_W'(-mom) : '0;
        old_up   = rd_reg[MOM_W-1] ? '0 : rd_reg;
        old_down = rd_reg[MOM_W-1] ? MOM_W'(-rd_reg) : '0;

        up_next   = up_reg - (evict ? SUM_W'(old_up) : '0) + SUM_W'(new_up);
        down_next = down_reg - (evict ? SUM_W'(old_down) : '0) + SUM_W'(new_down);

        total = {1'b0, up_reg} + {1'b0, down_reg};
        diff  = (up_reg >= down_reg) ? up_reg - down_reg : down_reg - up_reg;
        xs    = prod_reg[PROD_W-1:FRAC_BITS-1];

        avg_next = neg_reg ? avg_reg - div_q : avg_reg + div_q;

        div_start = cmd.ratio_ld || cmd.step_ld;
        if (cmd.ratio_ld)
        begin
            div_count   = CNT_W'(RATIO_W);
            div_rem     = TOT_W'(diff >> 1);
            div_bits    = {diff[0], {(DIV_BITS-1){1'b0}}};
            div_divisor = total;
        end
        else
        begin
            div_count   = CNT_W'(DIV_BITS);
            div_rem     = TOT_W'(xs[XS_W-1:DIV_BITS]);
            div_bits    = xs[DIV_BITS-1:0];
            div_divisor = TOT_W'(v_eff) + TOT_W'(1);
        end
    end

    vaa_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .count_init (div_count),
        .rem_init   (div_rem),
        .bits_init  (div_bits),
        .divisor    (div_divisor),
        .busy       (div_busy),
        .quotient   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmo_reg <= CMO_PERIOD_RESET;
            vid_reg <= VIDYA_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CMO_PERIOD:   cmo_reg <= cfg_data;
                REG_VIDYA_PERIOD: vid_reg <= cfg_data;
                default:          cmo_reg <= cmo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            last_reg <= '0;
            ptr_reg  <= '0;
            up_reg   <= '0;
            down_reg <= '0;
            avg_reg  <= '0;
        end
        else
        begin
            if (cmd.capture && sample.series_start)
            begin
                n_reg    <= '0;
                last_reg <= '0;
                ptr_reg  <= '0;
                up_reg   <= '0;
                down_reg <= '0;
                avg_reg  <= '0;
            end
            else if (cmd.prep)
            begin
                ptr_reg <= ptr_wrap;
            end
            else if (cmd.update)
            begin
                if (mom_on)
                begin
                    up_reg   <= up_next;
                    down_reg <= down_next;
                    ptr_reg  <= ptr_adv;
                end
                last_reg <= price_reg;
                n_reg    <= (n_reg == IDX_MAX) ? n_reg : n_reg + IDX_W'(1);
            end
            else if (cmd.load_out)
            begin
                avg_reg <= avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            rd_reg <= ring[ptr_wrap];
        end
        if (cmd.update && mom_on)
        begin
            ring[ptr_reg] <= mom;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            price_reg <= sample.price;
        end
        if (cmd.ratio_ld)
        begin
            tot_zero_reg <= (total == '0);
        end
        if (cmd.ratio_take)
        begin
            k_reg   <= tot_zero_reg ? '0 : div_q[RATIO_W-1:0];
            neg_reg <= (price_reg < avg_reg);
            mag_reg <= (price_reg < avg_reg) ? avg_reg - price_reg : price_reg - avg_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(k_reg) * PROD_W'(mag_reg);
        end
        if (cmd.load_out)
        begin
            result_reg.average <= avg_next;
            result_reg.ratio   <= k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign sts.emit     = ({1'b0, n_reg} >= (IDX_W+1)'(p_eff) + (IDX_W+1)'(v_eff));
    assign sts.div_busy = div_busy;
    assign sts.out_free = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `VAA_ASSERT_SAME(a_div_idle_at_start, div_start, !div_busy)
    `VAA_ASSERT_NEXT(a_div_runs_after_start, div_start, div_busy)
    `VAA_ASSERT_SAME(a_ratio_at_most_one, cmd.mul, k_reg <= RATIO_ONE)
    `VAA_ASSERT_SAME(a_step_within_gap, cmd.load_out, div_q <= mag_reg)
    `VAA_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, !result_valid_reg || !result_stall)

endmodule

[rtl/vaa_ctrl.sv]
module vaa_ctrl
    import vaa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_RLD  = 4'd3;
    localparam logic [3:0] ST_RDIV = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_SLD  = 4'd6;
    localparam logic [3:0] ST_SDIV = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = sts.emit ? ST_RLD : ST_IDLE;
            end
            ST_RLD:
            begin
                cmd.ratio_ld = 1'b1;
                state_next   = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.ratio_take = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SLD;
            end
            ST_SLD:
            begin
                cmd.step_ld = 1'b1;
                state_next  = ST_SDIV;
            end
            ST_SDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);

endmodule

[rtl/vidya_adaptive_average.sv]
// A sample that yields a result passes prep, update, ratio load, ratio divide, multiply,
// step load, step divide and output (which waits on result_stall); one that yields none
// passes only prep and update. No sample is taken outside idle. The pace is set by one
// shared one-bit-per-cycle divider: 17 steps for the ratio and 32 steps for the average
// step. Reset clears the series state and sets cmo_period to 10 and vidya_period to 14;
// the momentum memory is not cleared, so the block accepts samples right after reset.
module vidya_adaptive_average
    import vaa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    vaa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    vaa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
